/* rtl/julia_escape_time_pixel_macros.svh */
// Assertion helpers for the RTL (included by jet_core).
`ifndef JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH

`ifndef ASSERT_OFF
`define JET_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JET_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define JET_ASSERT(name, prop, msg)
`define JET_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

/* rtl/jet_pkg.sv */
package jet_pkg;

  localparam int unsigned COORD_W     = 10;
  localparam int unsigned OFS_W       = 13;
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned STEP_W      = 31;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned DIVIDEND_W  = 2 * COUNT_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIVIDEND_W + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [7:0]         ALPHA          = 8'hFF;
  localparam logic [STEP_W-1:0]  STEP_RESET     = 31'd1048576;
  localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 8'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_REAL      = 3'd0,
    CFG_C_IMAG      = 3'd1,
    CFG_CENTER_REAL = 3'd2,
    CFG_CENTER_IMAG = 3'd3,
    CFG_PIXEL_STEP  = 3'd4,
    CFG_MAX_ITER    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SQUARE,
    BS_SUM,
    BS_DIV_GO,
    BS_DIV_WAIT
  } back_state_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [COUNT_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/jet_fifo.sv */
module jet_fifo #(
  parameter int unsigned WIDTH = 90
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned DEPTH = jet_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

/* rtl/jet_front.sv */
module jet_front #(
  parameter int unsigned SCREEN_WIDTH  = 1024,
  parameter int unsigned SCREEN_HEIGHT = 1024,
  parameter int unsigned ZW            = 45
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [jet_pkg::COORD_W-1:0]        pix_x_i,
  input  logic [jet_pkg::COORD_W-1:0]        pix_y_i,
  input  logic [jet_pkg::STEP_W-1:0]         pixel_step_i,
  input  logic signed [jet_pkg::CFG_W-1:0]   center_real_i,
  input  logic signed [jet_pkg::CFG_W-1:0]   center_imag_i,
  output logic                               push_o,
  input  logic                               full_i,
  output logic signed [ZW-1:0]               zr_o,
  output logic signed [ZW-1:0]               zi_o
);

  localparam int unsigned OW = jet_pkg::OFS_W;
  localparam int unsigned CW = jet_pkg::COORD_W;
  localparam logic signed [OW-1:0] HALF_W = OW'(SCREEN_WIDTH / 2);
  localparam logic signed [OW-1:0] HALF_H = OW'(SCREEN_HEIGHT / 2);

  jet_pkg::front_state_e state_q, state_d;
  logic signed [OW-1:0]  px_q, py_q;
  logic signed [ZW-1:0]  prod_r_q, prod_i_q;
  logic signed [jet_pkg::STEP_W:0] step_s;

  assign step_s = $signed({1'b0, pixel_step_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jet_pkg::FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    busy_o  = 1'b1;
    push_o  = 1'b0;
    unique case (state_q)
      jet_pkg::FS_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          state_d = jet_pkg::FS_MUL;
        end
      end
      jet_pkg::FS_MUL: begin
        state_d = jet_pkg::FS_PUSH;
      end
      jet_pkg::FS_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = jet_pkg::FS_IDLE;
        end
      end
      default: begin
        state_d = jet_pkg::FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == jet_pkg::FS_IDLE && start_i) begin
      px_q <= $signed({{(OW-CW){1'b0}}, pix_x_i}) - HALF_W;
      py_q <= $signed({{(OW-CW){1'b0}}, pix_y_i}) - HALF_H;
    end
    if (state_q == jet_pkg::FS_MUL) begin
      prod_r_q <= ZW'(px_q) * ZW'(step_s);
      prod_i_q <= ZW'(py_q) * ZW'(step_s);
    end
  end

  assign zr_o = prod_r_q + ZW'(center_real_i);
  assign zi_o = prod_i_q + ZW'(center_imag_i);

endmodule

/* rtl/jet_div.sv */
module jet_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jet_pkg::div_req_t req_i,
  output jet_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DW  = jet_pkg::DIVIDEND_W;
  localparam int unsigned VW  = jet_pkg::COUNT_W;
  localparam int unsigned NW  = jet_pkg::DIV_CNT_W;

  logic          busy_q, done_q;
  logic [NW-1:0] cnt_q;
  logic [VW-1:0] rem_q, div_q;
  logic [DW-1:0] quo_q;
  logic [VW:0]   shifted;
  logic          ge;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign ge      = (shifted >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= NW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - NW'(1);
        if (cnt_q == NW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? VW'(shifted - {1'b0, div_q}) : shifted[VW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* rtl/jet_core.sv */
`include "julia_escape_time_pixel_macros.svh"

module jet_core #(
  parameter int unsigned FRACTION_BITS = 28,
  parameter int unsigned ZW            = 45
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [jet_pkg::CFG_W-1:0]  c_real_i,
  input  logic signed [jet_pkg::CFG_W-1:0]  c_imag_i,
  input  logic [jet_pkg::COUNT_W-1:0]       max_iter_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  input  logic signed [ZW-1:0]              zr_i,
  input  logic signed [ZW-1:0]              zi_i,
  output jet_pkg::div_req_t                 div_req_o,
  input  jet_pkg::div_rsp_t                 div_rsp_i,
  output logic                              result_valid_o,
  output logic [jet_pkg::COUNT_W-1:0]       iteration_count_o,
  output logic [jet_pkg::WORD_W-1:0]        pixel_word_o
);

  localparam int unsigned SW = FRACTION_BITS + 2;
  localparam int unsigned NW = jet_pkg::COUNT_W;
  localparam logic signed [ZW-1:0] TWO     = ZW'(2) << FRACTION_BITS;
  localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
  localparam logic signed [ZW-1:0] FOUR    = ZW'(1) << (FRACTION_BITS + 2);

  jet_pkg::back_state_e state_q, state_d;
  logic signed [ZW-1:0] zr_q, zi_q;
  logic signed [ZW-1:0] sq_r_q, sq_i_q, cross_q;
  logic [NW-1:0]        count_q;
  logic                 result_valid_q;
  logic [NW-1:0]        count_out_q, level_q;

  logic signed [SW-1:0]   zr_s, zi_s;
  logic signed [2*SW-1:0] pr_rr, pr_ii, pr_ri;
  logic signed [ZW-1:0]   mag_sum;
  logic                   out_range, div_start;

  assign zr_s  = zr_q[SW-1:0];
  assign zi_s  = zi_q[SW-1:0];
  assign pr_rr = zr_s * zr_s;
  assign pr_ii = zi_s * zi_s;
  assign pr_ri = zr_s * zi_s;

  assign out_range = (zr_q >= TWO) || (zr_q <= NEG_TWO) ||
                     (zi_q >= TWO) || (zi_q <= NEG_TWO);
  assign mag_sum   = sq_r_q + sq_i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= jet_pkg::BS_IDLE;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= (state_q == jet_pkg::BS_DIV_WAIT) && div_rsp_i.done;
    end
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      jet_pkg::BS_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = jet_pkg::BS_SQUARE;
        end
      end
      jet_pkg::BS_SQUARE: begin
        if ((count_q >= max_iter_i) || out_range) begin
          state_d = jet_pkg::BS_DIV_GO;
        end else begin
          state_d = jet_pkg::BS_SUM;
        end
      end
      jet_pkg::BS_SUM: begin
        if (mag_sum >= FOUR) begin
          state_d = jet_pkg::BS_DIV_GO;
        end else begin
          state_d = jet_pkg::BS_SQUARE;
        end
      end
      jet_pkg::BS_DIV_GO: begin
        div_start = 1'b1;
        state_d   = jet_pkg::BS_DIV_WAIT;
      end
      jet_pkg::BS_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = jet_pkg::BS_IDLE;
        end
      end
      default: begin
        state_d = jet_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      zr_q    <= zr_i;
      zi_q    <= zi_i;
      count_q <= '0;
    end
    if (state_q == jet_pkg::BS_SQUARE) begin
      sq_r_q  <= ZW'(pr_rr >>> FRACTION_BITS);
      sq_i_q  <= ZW'(pr_ii >>> FRACTION_BITS);
      cross_q <= ZW'(pr_ri >>> (FRACTION_BITS - 1));
    end
    if (state_q == jet_pkg::BS_SUM && mag_sum < FOUR) begin
      zr_q    <= sq_r_q - sq_i_q + ZW'(c_real_i);
      zi_q    <= cross_q + ZW'(c_imag_i);
      count_q <= count_q + NW'(1);
    end
    if (state_q == jet_pkg::BS_DIV_WAIT && div_rsp_i.done) begin
      count_out_q <= count_q;
      level_q     <= (max_iter_i == '0) ? '0 : div_rsp_i.quotient[NW-1:0];
    end
  end

  assign div_req_o.start    = div_start;
  assign div_req_o.dividend = {count_q, {NW{1'b0}}} - {{NW{1'b0}}, count_q};
  assign div_req_o.divisor  = max_iter_i;

  assign result_valid_o    = result_valid_q;
  assign iteration_count_o = count_out_q;
  assign pixel_word_o      = {level_q, level_q, level_q, jet_pkg::ALPHA};

  `JET_ASSERT(a_strobe_single, result_valid_o |=> !result_valid_o, "result strobe longer than one cycle")
  `JET_ASSERT(a_div_latency, div_req_o.start |=> !div_rsp_i.done, "divider answered too early")
  `JET_ASSERT_ALWAYS(a_no_strobe_in_loop, (state_q == jet_pkg::BS_SQUARE) |-> !result_valid_o, "result shown mid iteration")

endmodule

/* rtl/julia_escape_time_pixel.sv */
// Julia set escape-time engine for one pixel per request. A request is taken when start is
// high and busy is low; the front registers the pixel's offset from the screen centre, scales
// it by the pixel step and, once the queue has room, parks the start point in a two-entry
// queue, so busy drops again while the back still iterates the previous pixel. Each iteration
// of the back registers the squares, then does the escape compare and update; after that a
// shift-subtract divider forms the grey level. Each result appears on the result ports
// for exactly one cycle with result_valid_o high and cannot be held off; results come out
// in request order. Registers are written through the cfg port, which is always ready,
// and should only change while no request is outstanding.
module julia_escape_time_pixel #(
  parameter int unsigned SCREEN_WIDTH  = 1024,
  parameter int unsigned SCREEN_HEIGHT = 1024,
  parameter int unsigned FRACTION_BITS = 28
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [jet_pkg::COORD_W-1:0]     pix_x_i,
  input  logic [jet_pkg::COORD_W-1:0]     pix_y_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [jet_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [jet_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                            result_valid_o,
  output logic [jet_pkg::COUNT_W-1:0]     iteration_count_o,
  output logic [jet_pkg::WORD_W-1:0]      pixel_word_o
);

  localparam int unsigned ZW = (FRACTION_BITS + 6 > 45) ? FRACTION_BITS + 6 : 45;
  localparam int unsigned SW = jet_pkg::STEP_W;
  localparam int unsigned NW = jet_pkg::COUNT_W;

  logic signed [jet_pkg::CFG_W-1:0] c_real_q, c_imag_q, center_real_q, center_imag_q;
  logic [SW-1:0]                    pixel_step_q;
  logic [NW-1:0]                    max_iter_q;

  logic                 push, full, pop, empty;
  logic signed [ZW-1:0] zr_f, zi_f;
  logic [2*ZW-1:0]      q_rdata;
  jet_pkg::div_req_t    div_req;
  jet_pkg::div_rsp_t    div_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q      <= '0;
      c_imag_q      <= '0;
      center_real_q <= '0;
      center_imag_q <= '0;
      pixel_step_q  <= jet_pkg::STEP_RESET;
      max_iter_q    <= jet_pkg::MAX_ITER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (jet_pkg::cfg_reg_e'(cfg_index_i))
        jet_pkg::CFG_C_REAL:      c_real_q      <= cfg_data_i;
        jet_pkg::CFG_C_IMAG:      c_imag_q      <= cfg_data_i;
        jet_pkg::CFG_CENTER_REAL: center_real_q <= cfg_data_i;
        jet_pkg::CFG_CENTER_IMAG: center_imag_q <= cfg_data_i;
        jet_pkg::CFG_PIXEL_STEP:  pixel_step_q  <= cfg_data_i[SW-1:0];
        jet_pkg::CFG_MAX_ITER:    max_iter_q    <= cfg_data_i[NW-1:0];
        default: begin
        end
      endcase
    end
  end

  jet_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ZW            (ZW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .pix_x_i       (pix_x_i),
    .pix_y_i       (pix_y_i),
    .pixel_step_i  (pixel_step_q),
    .center_real_i (center_real_q),
    .center_imag_i (center_imag_q),
    .push_o        (push),
    .full_i        (full),
    .zr_o          (zr_f),
    .zi_o          (zi_f)
  );

  jet_fifo #(
    .WIDTH (2 * ZW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({zr_f, zi_f}),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .empty_o (empty)
  );

  jet_core #(
    .FRACTION_BITS (FRACTION_BITS),
    .ZW            (ZW)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .c_real_i          (c_real_q),
    .c_imag_i          (c_imag_q),
    .max_iter_i        (max_iter_q),
    .empty_i           (empty),
    .pop_o             (pop),
    .zr_i              ($signed(q_rdata[2*ZW-1:ZW])),
    .zi_i              ($signed(q_rdata[ZW-1:0])),
    .div_req_o         (div_req),
    .div_rsp_i         (div_rsp),
    .result_valid_o    (result_valid_o),
    .iteration_count_o (iteration_count_o),
    .pixel_word_o      (pixel_word_o)
  );

  jet_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule
